// File: sv/npc_pkg.sv
`default_nettype none
package npc_pkg;

    localparam int CH_W   = 8;
    localparam int IN_W   = 9;
    localparam int SIZE_W = 9;
    localparam int IDX_W  = 8;
    localparam int SQ_W   = 2 * CH_W;
    // three squares of 8-bit differences fit in 18 bits
    localparam int DIST_W = SQ_W + 2;
    localparam logic [DIST_W-1:0] DIST_INIT = '1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic query_init;
        logic issue;
    } ctl_t;

    typedef struct packed {
        logic issue_more;
        logic pipe_idle;
    } status_t;

    function automatic logic [CH_W-1:0] clamp_ch(input logic [IN_W-1:0] v);
        return v[IN_W-1] ? {CH_W{1'b1}} : v[CH_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage
`default_nettype wire

// File: sv/nearest_palette_color.sv
`default_nettype none
// Nearest palette color search by squared Euclidean RGB distance.
// Request channel: start/busy. A request is taken when start is high and
// busy is low. cmd selects a load (write one palette entry at entry_index,
// low 8 bits per channel kept) or a query (channels clamped to 255).
// A load raises no busy and gives no result; a new
// request may follow in the next cycle.
// A query searches the first min(palette_size, PALETTE_DEPTH, 256) entries,
// one RAM read per cycle through a read/square/compare pipeline. Busy stays
// high through the search until result_valid pulses for one cycle, in the
// last busy cycle, carrying best_index (lowest index on ties, 0 for an
// empty palette). A new query is taken only once busy is low again.
// The receiver cannot stall: the result is presented for one cycle only.
// Config: cfg_valid/cfg_ready writes palette_size; cfg_ready is always high.
// Write it only while no query is in flight.
// Reset sets palette_size to 256 and returns to idle; palette contents are
// undefined until loaded.
module nearest_palette_color
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              cmd,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [IN_W-1:0]   red,
    input  wire logic [IN_W-1:0]   green,
    input  wire logic [IN_W-1:0]   blue,
    output logic                   result_valid,
    output logic      [IDX_W-1:0]  best_index,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    ctl_t    ctl;
    status_t status;

    assign cfg_ready = 1'b1;

    npc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .status       (status),
        .ctl          (ctl),
        .busy         (busy),
        .result_valid (result_valid)
    );

    npc_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .best_index  (best_index)
    );

endmodule
`default_nettype wire

// File: sv/npc_ram.sv
`default_nettype none
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/npc_datapath.sv
`default_nettype none
module npc_datapath
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_t              ctl,
    output status_t                status,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [IN_W-1:0]   red,
    input  wire logic [IN_W-1:0]   green,
    input  wire logic [IN_W-1:0]   blue,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_data,
    output logic      [IDX_W-1:0]  best_index
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int MAX_SEARCH = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam logic [SIZE_W-1:0] MAX_CNT = SIZE_W'(MAX_SEARCH);

    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   cnt_reg;
    logic [SIZE_W-1:0]   addr_reg;
    logic [CH_W-1:0]     qr_reg, qg_reg, qb_reg;
    logic                v1_reg, v2_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg;
    logic [SQ_W-1:0]     sqr_reg, sqg_reg, sqb_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_reg;
    logic [3*CH_W-1:0]   rd_data;
    logic                wr_en;
    logic [DIST_W-1:0]   dist_sum;

    assign wr_en = ctl.load_en && (int'(entry_index) < PALETTE_DEPTH);

    npc_ram #(
        .WIDTH (3 * CH_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(entry_index)),
        .wdata ({red[CH_W-1:0], green[CH_W-1:0], blue[CH_W-1:0]}),
        .re    (ctl.issue),
        .raddr (AW'(addr_reg)),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    // query setup and address walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            addr_reg <= '0;
        end
        else if (ctl.query_init)
        begin
            cnt_reg  <= (size_reg > MAX_CNT) ? MAX_CNT : size_reg;
            addr_reg <= '0;
        end
        else if (ctl.issue)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.query_init)
        begin
            qr_reg <= clamp_ch(red);
            qg_reg <= clamp_ch(green);
            qb_reg <= clamp_ch(blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
        end
    end

    // squares stage
    always_ff @(posedge clk)
    begin
        idx1_reg <= addr_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        sqr_reg  <= sq_diff(rd_data[3*CH_W-1:2*CH_W], qr_reg);
        sqg_reg  <= sq_diff(rd_data[2*CH_W-1:CH_W], qg_reg);
        sqb_reg  <= sq_diff(rd_data[CH_W-1:0], qb_reg);
    end

    assign dist_sum = DIST_W'(sqr_reg) + DIST_W'(sqg_reg) + DIST_W'(sqb_reg);

    // strict compare keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= DIST_INIT;
            best_reg      <= '0;
        end
        else if (ctl.query_init)
        begin
            best_dist_reg <= DIST_INIT;
            best_reg      <= '0;
        end
        else if (v2_reg && (dist_sum < best_dist_reg))
        begin
            best_dist_reg <= dist_sum;
            best_reg      <= idx2_reg;
        end
    end

    assign status.issue_more = (addr_reg < cnt_reg);
    assign status.pipe_idle  = !v1_reg && !v2_reg;
    assign best_index        = best_reg;

endmodule
`default_nettype wire

// File: sv/npc_ctrl.sv
`default_nettype none
module npc_ctrl
    import npc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    cmd,
    input  wire status_t status,
    output ctl_t         ctl,
    output logic         busy,
    output logic         result_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (cmd == CMD_QUERY))
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!status.issue_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_idle)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                ctl.load_en    = start && (cmd == CMD_LOAD);
                ctl.query_init = start && (cmd == CMD_QUERY);
            end
            ST_SEARCH:
            begin
                ctl.issue = status.issue_more;
            end
            ST_DRAIN:
            begin
                ctl.issue = 1'b0;
            end
            ST_RESULT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire
